// File: hdl/bsa_pkg.sv
// Shared types and constants for the binding slot allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package bsa_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key_id;
    logic [31:0] key_offset;
    logic [31:0] key_size;
    logic        prioritize;
  } req_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic       hit;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] offset;
    logic [31:0] size;
  } slot_key_t;

  typedef struct packed {
    logic start;
    logic age_up;
    logic scan;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic is_unbind;
  } ctrl_status_t;

  localparam logic       REQ_BIND       = 1'b0;
  localparam logic       REQ_UNBIND     = 1'b1;
  localparam logic [7:0] AGE_EMPTY      = 8'd255;
  localparam logic [7:0] AGE_MAX        = 8'd254;
  localparam logic [7:0] AGE_MIN        = 8'd0;
  localparam logic [4:0] SLOT_COUNT_RST = 5'd16;
  localparam logic       REG_SLOT_COUNT = 1'b0;

endpackage

// File: hdl/bsa_ctrl.sv
// Controller state machine of the binding slot allocator.
// Sequences aging, scan, commit and result hand-off; uses bsa_pkg.
module bsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  bsa_pkg::ctrl_status_t status,
  output bsa_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.start    = in_valid;
      S_AGE:   cmd.age_up   = 1'b1;
      S_SCAN:  cmd.scan     = 1'b1;
      S_WRITE: cmd.commit   = 1'b1;
      S_DONE:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_AGE;
          end
        end
        S_AGE: state <= S_SCAN;
        S_SCAN: begin
          if (status.done) begin
            state <= status.is_unbind ? S_DONE : S_WRITE;
          end
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/bsa_datapath.sv
// Datapath of the binding slot allocator: age lanes, key memory, scan and result.
// Driven by bsa_ctrl through command and status structs; uses bsa_pkg.
module bsa_datapath #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bsa_pkg::req_t         in_data,
  input  logic [4:0]            slot_count,
  input  bsa_pkg::ctrl_cmd_t    cmd,
  output bsa_pkg::ctrl_status_t status,
  output bsa_pkg::rsp_t         out_data
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  bsa_pkg::req_t     req;
  bsa_pkg::slot_key_t key_mem [MAX_SLOTS];
  bsa_pkg::slot_key_t rd_key;
  bsa_pkg::rsp_t     out_q;

  logic [7:0]    age      [MAX_SLOTS];
  logic [7:0]    age_next [MAX_SLOTS];
  logic [CW-1:0] issue_cnt;
  logic [CW-1:0] n_active;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] cmp_idx;
  logic [IW-1:0] high_idx;
  logic [IW-1:0] pos;
  logic [IW-1:0] first;
  logic [IW-1:0] final_pos;
  logic [7:0]    high_age;
  logic [7:0]    cur_age;
  logic          cmp_valid;
  logic          found;
  logic          hit_q;
  logic          freed;
  logic          is_unbind;
  logic          is_empty;
  logic          id_eq;
  logic          key_eq;
  logic          stop;
  logic          free_en;
  logic          issue_more;

  always_comb begin
    if (slot_count == '0) begin
      n_active = CW'(1);
    end else if (32'(slot_count) > 32'(MAX_SLOTS)) begin
      n_active = CW'(MAX_SLOTS);
    end else begin
      n_active = CW'(slot_count);
    end
  end

  assign is_unbind  = (req.req_type == bsa_pkg::REQ_UNBIND);
  assign rd_addr    = issue_cnt[IW-1:0];
  assign issue_more = (issue_cnt < n_active);
  assign cur_age    = age[cmp_idx];
  assign is_empty   = (cur_age == bsa_pkg::AGE_EMPTY);
  assign id_eq      = (rd_key.id == req.key_id);
  assign key_eq     = id_eq && (rd_key.offset == req.key_offset)
                      && (rd_key.size == req.key_size);
  assign stop       = cmp_valid && !is_unbind && (is_empty || key_eq);
  assign free_en    = cmd.scan && cmp_valid && is_unbind && !is_empty && id_eq;
  assign final_pos  = found ? pos : high_idx;

  assign status.done      = stop || (!cmp_valid && (issue_cnt == n_active));
  assign status.is_unbind = is_unbind;
  assign out_data         = out_q;

  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      age_next[j] = age[j];
      if (CW'(j) < n_active) begin
        if (cmd.age_up && !is_unbind && req.prioritize) begin
          if (age[j] != bsa_pkg::AGE_EMPTY && age[j] != bsa_pkg::AGE_MAX) begin
            age_next[j] = age[j] + 8'd1;
          end
        end
        if (free_en) begin
          if (age[j] != bsa_pkg::AGE_EMPTY && age[j] >= cur_age
              && age[j] != bsa_pkg::AGE_MIN) begin
            age_next[j] = age[j] - 8'd1;
          end
          if (IW'(j) == cmp_idx) begin
            age_next[j] = bsa_pkg::AGE_EMPTY;
          end
        end
      end
      if (cmd.commit && IW'(j) == final_pos) begin
        age_next[j] = req.prioritize ? bsa_pkg::AGE_MIN : bsa_pkg::AGE_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_SLOTS; j++) begin
        age[j] <= bsa_pkg::AGE_EMPTY;
      end
    end else begin
      for (int j = 0; j < MAX_SLOTS; j++) begin
        age[j] <= age_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    if (cmd.commit) begin
      key_mem[final_pos] <= '{id: req.key_id, offset: req.key_offset, size: req.key_size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      issue_cnt <= '0;
    end else if (cmd.start) begin
      req       <= in_data;
      issue_cnt <= '0;
      cmp_valid <= 1'b0;
      high_idx  <= '0;
      high_age  <= '0;
      found     <= 1'b0;
      hit_q     <= 1'b0;
      freed     <= 1'b0;
      first     <= '0;
      pos       <= '0;
    end else if (cmd.scan) begin
      if (issue_more) begin
        cmp_idx   <= rd_addr;
        cmp_valid <= 1'b1;
        issue_cnt <= issue_cnt + CW'(1);
      end else begin
        cmp_valid <= 1'b0;
      end
      if (stop) begin
        found <= 1'b1;
        pos   <= cmp_idx;
        hit_q <= key_eq && !is_empty;
      end else if (cmp_valid && !is_unbind && high_age < cur_age) begin
        high_idx <= cmp_idx;
        high_age <= cur_age;
      end
      if (free_en) begin
        freed <= 1'b1;
        if (!freed) begin
          first <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_q.slot_index <= 4'(is_unbind ? first : final_pos);
      out_q.hit        <= is_unbind ? freed : hit_q;
    end
  end

endmodule

// File: hdl/binding_slot_allocator_unit.sv
// Top level of the binding slot allocator: configuration port and the
// controller/datapath pair. Uses bsa_pkg, bsa_ctrl and bsa_datapath.
//
// A binding request steps through aging, scan, commit and result hand-off.
// The scan stops at the first empty slot or key hit, or else runs to the end
// of the slots in use. An unbind always scans every slot in use and skips
// the commit, since it writes no key. The scan reads one slot key per cycle
// from the key memory. One request is worked on at a time. The next is taken
// in the cycle after the result is loaded into the output register. A result
// that cannot be loaded because the previous one is still stalled holds the
// block until the output register frees up.
// Writes to slot_count belong in idle periods only.
module binding_slot_allocator_unit #(
  parameter int MAX_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bsa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bsa_pkg::rsp_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  bsa_pkg::ctrl_cmd_t    cmd;
  bsa_pkg::ctrl_status_t status;
  logic [4:0]            slot_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bsa_pkg::REG_SLOT_COUNT) ? {27'd0, slot_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= bsa_pkg::SLOT_COUNT_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bsa_pkg::REG_SLOT_COUNT) begin
      slot_count <= pwdata[4:0];
    end
  end

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_data    (in_data),
    .slot_count (slot_count),
    .cmd        (cmd),
    .status     (status),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Request accepted but block did not become busy.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("Result loaded without raising out_valid.");

  a_commit_bind_only: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !status.is_unbind)
    else $error("Key commit issued during an unbind.");

  a_valid_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid rose without a result load.");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for binding_slot_allocator_unit: a local slot table
// predicts every result; random request gaps and result stalls shape traffic.
// Depends on bsa_pkg and the RTL of the binding slot allocator.
module testbench;

  localparam int TABLE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [2:0] ADDR_SLOT_COUNT = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bsa_pkg::req_t in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bsa_pkg::rsp_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  logic [7:0]  age_q [TABLE_SLOTS];
  logic [31:0] id_q [TABLE_SLOTS];
  logic [31:0] offset_q [TABLE_SLOTS];
  logic [31:0] size_q [TABLE_SLOTS];
  logic [4:0]  slot_count_q = bsa_pkg::SLOT_COUNT_RST;

  bsa_pkg::rsp_t pending_slots [$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   bind_count = 0;
  int   unbind_count = 0;
  int   hit_count = 0;
  int   result_count = 0;
  int   setting_count = 0;
  int   long_hold = 0;
  bit   no_idle = 1'b0;

  binding_slot_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_slots.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      age_q[i] = bsa_pkg::AGE_EMPTY;
      id_q[i] = '0;
      offset_q[i] = '0;
      size_q[i] = '0;
    end
  end

  function automatic bsa_pkg::rsp_t predict_binding(bsa_pkg::req_t r);
    int n;
    int pos;
    int high;
    bit found;
    bit hit;
    logic [7:0] floor_age;
    bsa_pkg::rsp_t rsp;
    n = (slot_count_q == 0) ? 1 : (slot_count_q > TABLE_SLOTS) ? TABLE_SLOTS : slot_count_q;
    pos = 0;
    high = 0;
    found = 1'b0;
    hit = 1'b0;
    if (r.req_type == bsa_pkg::REQ_BIND) begin
      if (r.prioritize) begin
        for (int i = 0; i < n; i++) begin
          if (age_q[i] != bsa_pkg::AGE_EMPTY && age_q[i] != bsa_pkg::AGE_MAX) begin
            age_q[i] = age_q[i] + 8'd1;
          end
        end
      end
      for (int i = 0; i < n && !found; i++) begin
        if (age_q[i] == bsa_pkg::AGE_EMPTY) begin
          pos = i;
          found = 1'b1;
        end else if (id_q[i] == r.key_id && offset_q[i] == r.key_offset &&
                     size_q[i] == r.key_size) begin
          pos = i;
          found = 1'b1;
          hit = 1'b1;
        end else if (age_q[high] < age_q[i]) begin
          high = i;
        end
      end
      if (!found) pos = high;
      age_q[pos] = r.prioritize ? bsa_pkg::AGE_MIN : bsa_pkg::AGE_MAX;
      id_q[pos] = r.key_id;
      offset_q[pos] = r.key_offset;
      size_q[pos] = r.key_size;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (age_q[i] != bsa_pkg::AGE_EMPTY && id_q[i] == r.key_id) begin
          floor_age = age_q[i];
          for (int j = 0; j < n; j++) begin
            if (age_q[j] != bsa_pkg::AGE_EMPTY && age_q[j] >= floor_age &&
                age_q[j] != bsa_pkg::AGE_MIN)
              age_q[j] = age_q[j] - 8'd1;
          end
          age_q[i] = bsa_pkg::AGE_EMPTY;
          id_q[i] = '0;
          offset_q[i] = '0;
          size_q[i] = '0;
          if (!hit) pos = i;
          hit = 1'b1;
        end
      end
    end
    rsp.slot_index = pos[3:0];
    rsp.hit = hit;
    return rsp;
  endfunction

  function automatic bsa_pkg::req_t random_request(int pool);
    bsa_pkg::req_t r;
    int pick;
    pick = $urandom_range(0, pool - 1);
    r.req_type = ($urandom_range(0, 3) == 0) ? bsa_pkg::REQ_UNBIND : bsa_pkg::REQ_BIND;
    r.prioritize = 1'($urandom_range(0, 1));
    r.key_id = 32'h0001_0000 + pick;
    r.key_offset = $urandom_range(0, 1) << 12;
    r.key_size = 32'h100;
    if ($urandom_range(0, 9) == 0) begin
      r.key_id = $urandom();
      r.key_offset = $urandom();
      r.key_size = $urandom();
    end
    return r;
  endfunction

  function automatic bsa_pkg::req_t make_request(logic kind, logic [31:0] id,
                                                 logic [31:0] offset,
                                                 logic [31:0] size, logic prio);
    bsa_pkg::req_t r;
    r.req_type = kind;
    r.key_id = id;
    r.key_offset = offset;
    r.key_size = size;
    r.prioritize = prio;
    return r;
  endfunction

  task automatic send_request(input bsa_pkg::req_t r);
    int gap;
    bsa_pkg::rsp_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_binding(r);
    pending_slots.push_back(predicted);
    if (r.req_type == bsa_pkg::REQ_BIND) bind_count++;
    else unbind_count++;
    if (predicted.hit) hit_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [4:0] value);
    logic [31:0] noise;
    noise = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {noise[31:5], value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if ((addr >> 2) == bsa_pkg::REG_SLOT_COUNT) slot_count_q = value;
    setting_count++;
  endtask

  task automatic check_slot_count_register();
    logic [31:0] data;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SLOT_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (data !== {27'b0, slot_count_q}) begin
      $display("%0t: slot_count read expected %0d got %0d", $time, slot_count_q, data);
      error_count++;
    end
  endtask

  task automatic test_register_reset();
    check_slot_count_register();
  endtask

  task automatic test_directed_cases();
    send_request(make_request(bsa_pkg::REQ_BIND, 32'h0, 32'h0, 32'h0, 1'b0));
    send_request(make_request(bsa_pkg::REQ_BIND, 32'h0, 32'h0, 32'h0, 1'b1));
    send_request(make_request(bsa_pkg::REQ_BIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b1));
    send_request(make_request(bsa_pkg::REQ_UNBIND, 32'h1234_5678, 32'h0, 32'h0, 1'b0));
    send_request(make_request(bsa_pkg::REQ_UNBIND, 32'h0, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b1));
    send_request(make_request(bsa_pkg::REQ_UNBIND, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0));
    for (int k = 0; k < TABLE_SLOTS; k++)
      send_request(make_request(bsa_pkg::REQ_BIND, k + 1, 32'h40 * k, 32'h10, k[0]));
    send_request(make_request(bsa_pkg::REQ_BIND, 32'd100, 32'h0, 32'h10, 1'b0));
    send_request(make_request(bsa_pkg::REQ_BIND, 32'd101, 32'h0, 32'h10, 1'b1));
    send_request(make_request(bsa_pkg::REQ_UNBIND, 32'd3, 32'h0, 32'h0, 1'b0));
    wait_idle();
  endtask

  task automatic test_slot_count_limits();
    logic [4:0] settings [5];
    settings = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd16};
    for (int s = 0; s < 5; s++) begin
      write_register(ADDR_SLOT_COUNT, settings[s]);
      check_slot_count_register();
      if (s == 2) write_register(ADDR_UNUSED, 5'd3);
      for (int k = 0; k < 12; k++) send_request(random_request(4));
      wait_idle();
    end
  endtask

  task automatic test_output_hold_off();
    long_hold = 200;
    no_idle = 1'b1;
    for (int k = 0; k < 10; k++) send_request(random_request(6));
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [4:0] settings [10];
    int pool;
    settings = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd8, 5'd12, 5'd16, 5'd0, 5'd0};
    settings[8] = 5'($urandom_range(0, 31));
    settings[9] = 5'($urandom_range(0, 31));
    for (int s = 0; s < 10; s++) begin
      write_register(ADDR_SLOT_COUNT, settings[s]);
      pool = (settings[s] == 0) ? 2 : (settings[s] > TABLE_SLOTS) ? TABLE_SLOTS + 3 :
             settings[s] + 3;
      for (int k = 0; k < 125; k++) begin
        no_idle = (k >= 40 && k < 60);
        send_request(random_request(pool));
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  initial begin : result_checker
    int wait_cycles;
    bsa_pkg::rsp_t exp_rsp;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        wait_cycles = long_hold;
        long_hold = 0;
      end else if (no_idle) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 16);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      result_count++;
      if (pending_slots.size() == 0) begin
        $display("%0t: unexpected result slot_index %0d hit %0b", $time,
                 out_data.slot_index, out_data.hit);
        error_count++;
      end else begin
        exp_rsp = pending_slots.pop_front();
        if (out_data.slot_index !== exp_rsp.slot_index) begin
          $display("%0t: slot_index expected %0d got %0d", $time,
                   exp_rsp.slot_index, out_data.slot_index);
          error_count++;
        end
        if (out_data.hit !== exp_rsp.hit) begin
          $display("%0t: hit expected %0b got %0b", $time, exp_rsp.hit, out_data.hit);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_cases();
    test_slot_count_limits();
    test_output_hold_off();
    test_random_traffic();
    $display("Covered %0d binds and %0d unbinds, %0d of them hits, over %0d register writes.",
             bind_count, unbind_count, hit_count, setting_count);
    $display("Checked %0d results with %0d mismatches.", result_count, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: binding_slot_allocator_unit.f
hdl/bsa_pkg.sv
hdl/bsa_ctrl.sv
hdl/bsa_datapath.sv
hdl/binding_slot_allocator_unit.sv
verif/testbench.sv
